FILE: hdl/lrp_pkg.sv
// ----------------------------------------------------------------------------
// lrp_pkg: shared types and constants of the LR shift-reduce parse engine
// Request kinds, result kinds, table sizes and the queued request format.
// ----------------------------------------------------------------------------
package lrp_pkg;

   localparam int StateBits   = 8;
   localparam int TermBits    = 6;
   localparam int NontermBits = 6;
   localparam int RuleBits    = 8;
   localparam int LenBits     = 5;
   localparam int ActBits     = 10;

   localparam logic [LenBits-1:0] MaxRhs       = 5'd16;
   localparam logic [6:0]         MaxTerminals = 7'd64;
   localparam logic [5:0]         MaxReduce    = 6'd63;
   localparam logic [7:0]         StackTop     = 8'd255;

   // Request kinds
   localparam logic [2:0] KIND_ACTION = 3'd0;
   localparam logic [2:0] KIND_GOTO   = 3'd1;
   localparam logic [2:0] KIND_RULE   = 3'd2;
   localparam logic [2:0] KIND_TOKEN  = 3'd3;
   localparam logic [2:0] KIND_START  = 3'd4;

   // Action codes
   localparam logic [1:0] ACT_ERROR  = 2'd0;
   localparam logic [1:0] ACT_SHIFT  = 2'd1;
   localparam logic [1:0] ACT_REDUCE = 2'd2;
   localparam logic [1:0] ACT_ACCEPT = 2'd3;

   // Result kinds
   localparam logic [2:0] RES_REDUCE  = 3'd0;
   localparam logic [2:0] RES_ACCEPT  = 3'd1;
   localparam logic [2:0] RES_SYNTAX  = 3'd2;
   localparam logic [2:0] RES_UNKNOWN = 3'd3;
   localparam logic [2:0] RES_LIMIT   = 3'd4;

   // Configuration register indexes
   localparam logic CSR_TERMINAL_COUNT = 1'b0;
   localparam logic CSR_CONFLICT       = 1'b1;

   typedef struct packed {
      logic [2:0]             kind;
      logic [StateBits-1:0]   state_index;
      logic [TermBits-1:0]    column_index;
      logic [1:0]             action_code;
      logic [7:0]             action_value;
      logic [StateBits-1:0]   goto_target;
      logic [RuleBits-1:0]    rule_index;
      logic [LenBits-1:0]     rule_length;
      logic [NontermBits-1:0] rule_left;
      logic [TermBits-1:0]    token;
   } item_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic [7:0] rule;
      logic       last;
   } result_type;

endpackage

FILE: hdl/lrp_front.sv
// ----------------------------------------------------------------------------
// lrp_front: request intake and queue
// Accepts requests, drops unused kinds, clamps rule lengths, and queues them.
// ----------------------------------------------------------------------------
module lrp_front
   import lrp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_stall,
   input  item_type in_item,
   output logic     head_valid,
   output item_type head_item,
   input  logic     head_pop
);

   localparam int Depth = 4;

   item_type   q_ff [Depth];
   logic [1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0] count_ff, count_in;
   logic       push;
   item_type   cooked;

   always_comb begin
      cooked = in_item;
      if (in_item.rule_length > MaxRhs) begin
         cooked.rule_length = MaxRhs;
      end
   end

   // Kinds past the start request have no effect and are not queued.
   assign in_stall   = (count_ff == 3'(Depth));
   assign push       = in_valid && !in_stall && (in_item.kind <= KIND_START);
   assign head_valid = (count_ff != 3'd0);
   assign head_item  = q_ff[rp_ff];

   always_comb begin
      wp_in    = push ? wp_ff + 2'd1 : wp_ff;
      rp_in    = head_pop ? rp_ff + 2'd1 : rp_ff;
      count_in = count_ff + {2'b00, push} - {2'b00, head_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
      if (push) begin
         q_ff[wp_ff] <= cooked;
      end
   end

endmodule

FILE: hdl/lrp_back.sv
// ----------------------------------------------------------------------------
// lrp_back: parse execution unit
// Holds the tables and the state stack and walks the reduce/shift sequence.
// ----------------------------------------------------------------------------
module lrp_back
   import lrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  item_type   head_item,
   output logic       head_pop,
   input  logic [6:0] terminal_count,
   input  logic       tables_conflict,
   input  logic       out_ready,
   output result_type out_result
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_TOKEN = 7'b0000010,
      ST_ACT   = 7'b0000100,
      ST_RULE  = 7'b0001000,
      ST_STK   = 7'b0010000,
      ST_GOTO  = 7'b0100000,
      ST_FIN   = 7'b1000000
   } state_type;

   logic [ActBits-1:0]             act_mem  [1 << (StateBits + TermBits)];
   logic [StateBits-1:0]           goto_mem [1 << (StateBits + NontermBits)];
   logic [LenBits+NontermBits-1:0] rule_mem [1 << RuleBits];
   logic [StateBits-1:0]           stk_mem  [256];

   logic [ActBits-1:0]             act_q_ff;
   logic [StateBits-1:0]           goto_q_ff;
   logic [LenBits+NontermBits-1:0] rule_q_ff;
   logic [StateBits-1:0]           stk_q_ff;

   state_type              state_ff, state_in;
   logic [7:0]             sp_ff, sp_in;
   logic [StateBits-1:0]   top_ff, top_in;
   logic                   fin_ff, fin_in;
   logic [5:0]             n_ff, n_in;
   logic [TermBits-1:0]    tok_ff, tok_in;
   logic [7:0]             rule_ff, rule_in;
   logic [7:0]             base_ff, base_in;
   logic [NontermBits-1:0] left_ff, left_in;
   logic                   pend_ff, pend_in;
   logic [2:0]             pkind_ff, pkind_in;
   logic [7:0]             prule_ff, prule_in;

   logic                   stk_we;
   logic [7:0]             stk_waddr;
   logic [StateBits-1:0]   stk_wdata;
   logic [6:0]             limit;
   logic                   can_make;
   logic [LenBits-1:0]     rlen;
   logic [StateBits-1:0]   below;
   logic [8:0]             sp_minus;

   assign limit    = (terminal_count > MaxTerminals) ? MaxTerminals : terminal_count;
   assign can_make = !pend_ff || out_ready;
   assign rlen     = rule_q_ff[LenBits+NontermBits-1:NontermBits];
   assign sp_minus = {1'b0, sp_ff} - {4'b0000, rlen};
   assign below    = (base_ff == 8'd0) ? '0 : stk_q_ff;

   always_comb begin
      state_in  = state_ff;
      sp_in     = sp_ff;
      top_in    = top_ff;
      fin_in    = fin_ff;
      n_in      = n_ff;
      tok_in    = tok_ff;
      rule_in   = rule_ff;
      base_in   = base_ff;
      left_in   = left_ff;
      pend_in   = pend_ff;
      pkind_in  = pkind_ff;
      prule_in  = prule_ff;
      head_pop  = 1'b0;
      stk_we    = 1'b0;
      stk_waddr = '0;
      stk_wdata = '0;
      out_result = '{valid: 1'b0, kind: pkind_ff, rule: prule_ff, last: 1'b0};

      // A new result pushes any held one out as a non-final result.
      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               case (head_item.kind)
                  KIND_TOKEN: begin
                     if (tables_conflict) begin
                        fin_in = 1'b1; pend_in = 1'b1;
                        pkind_in = RES_SYNTAX; prule_in = '0; state_in = ST_FIN;
                     end else if (!fin_ff) begin
                        if ({1'b0, head_item.token} >= limit) begin
                           fin_in = 1'b1; pend_in = 1'b1;
                           pkind_in = RES_UNKNOWN; prule_in = '0; state_in = ST_FIN;
                        end else begin
                           tok_in = head_item.token; n_in = '0; state_in = ST_TOKEN;
                        end
                     end
                  end
                  KIND_START: begin
                     sp_in = '0; top_in = '0; fin_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_TOKEN: state_in = ST_ACT;
         ST_ACT: begin
            case (act_q_ff[9:8])
               ACT_SHIFT: begin
                  if (sp_ff != StackTop) begin
                     sp_in = sp_ff + 8'd1; top_in = act_q_ff[7:0];
                     stk_we = 1'b1; stk_waddr = sp_ff + 8'd1; stk_wdata = act_q_ff[7:0];
                     state_in = ST_FIN;
                  end else if (can_make) begin
                     out_result.valid = pend_ff;
                     pend_in = 1'b1; pkind_in = RES_LIMIT; prule_in = '0;
                     fin_in = 1'b1; state_in = ST_FIN;
                  end
               end
               ACT_REDUCE: begin
                  if (n_ff != MaxReduce) begin
                     rule_in = act_q_ff[7:0]; state_in = ST_RULE;
                  end else if (can_make) begin
                     out_result.valid = pend_ff;
                     pend_in = 1'b1; pkind_in = RES_LIMIT; prule_in = '0;
                     fin_in = 1'b1; state_in = ST_FIN;
                  end
               end
               default: begin
                  if (can_make) begin
                     out_result.valid = pend_ff;
                     pend_in = 1'b1; prule_in = '0;
                     pkind_in = (act_q_ff[9:8] == ACT_ACCEPT && tok_ff == '0) ?
                                RES_ACCEPT : RES_SYNTAX;
                     fin_in = 1'b1; state_in = ST_FIN;
                  end
               end
            endcase
         end
         ST_RULE: begin
            if (sp_minus[8]) begin
               if (can_make) begin
                  out_result.valid = pend_ff;
                  pend_in = 1'b1; pkind_in = RES_SYNTAX; prule_in = '0;
                  fin_in = 1'b1; state_in = ST_FIN;
               end
            end else begin
               base_in = sp_minus[7:0];
               left_in = rule_q_ff[NontermBits-1:0];
               state_in = ST_STK;
            end
         end
         ST_STK: begin
            if (base_ff != StackTop) begin
               state_in = ST_GOTO;
            end else if (can_make) begin
               out_result.valid = pend_ff;
               pend_in = 1'b1; pkind_in = RES_LIMIT; prule_in = '0;
               fin_in = 1'b1; state_in = ST_FIN;
            end
         end
         ST_GOTO: begin
            if (can_make) begin
               out_result.valid = pend_ff;
               pend_in = 1'b1; pkind_in = RES_REDUCE; prule_in = rule_ff;
               sp_in = base_ff + 8'd1; top_in = goto_q_ff;
               stk_we = 1'b1; stk_waddr = base_ff + 8'd1; stk_wdata = goto_q_ff;
               n_in = n_ff + 6'd1;
               state_in = ST_TOKEN;
            end
         end
         ST_FIN: begin
            if (!pend_ff) begin
               state_in = ST_IDLE;
            end else if (out_ready) begin
               out_result.valid = 1'b1;
               out_result.last  = 1'b1;
               pend_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= '0;
         top_ff   <= '0;
         fin_ff   <= 1'b0;
         pend_ff  <= 1'b0;
         n_ff     <= '0;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         top_ff   <= top_in;
         fin_ff   <= fin_in;
         pend_ff  <= pend_in;
         n_ff     <= n_in;
      end
      tok_ff   <= tok_in;
      rule_ff  <= rule_in;
      base_ff  <= base_in;
      left_ff  <= left_in;
      pkind_ff <= pkind_in;
      prule_ff <= prule_in;
   end

   // Table memories: written by queued table requests, read through a registered output.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && head_valid && head_item.kind == KIND_ACTION) begin
         act_mem[{head_item.state_index, head_item.column_index}] <=
            {head_item.action_code, head_item.action_value};
      end
      act_q_ff <= act_mem[{top_ff, tok_ff}];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && head_valid && head_item.kind == KIND_GOTO) begin
         goto_mem[{head_item.state_index, head_item.column_index}] <= head_item.goto_target;
      end
      goto_q_ff <= goto_mem[{below, left_ff}];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && head_valid && head_item.kind == KIND_RULE) begin
         rule_mem[head_item.rule_index] <= {head_item.rule_length, head_item.rule_left};
      end
      rule_q_ff <= rule_mem[act_q_ff[7:0]];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      stk_q_ff <= stk_mem[sp_minus[7:0]];
   end

endmodule

FILE: hdl/lr_shift_reduce_parse_engine.sv
// ----------------------------------------------------------------------------
// A table or start request waits in the queue and is taken by the execution
// unit while idle; a token steps through the token and action states, plus the
// rule, stack and goto states for each reduction. The execution unit takes one
// request at a time, while the queue accepts requests until it is full.
// Reset clears the queue, the stack pointer, the finished flag and the conflict
// register, sets the terminal count to 64; table memories hold whatever they held.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// lr_shift_reduce_parse_engine: table-driven LR shift-reduce parser
// A front queue takes requests; the execution unit runs the parse and feeds
// an output register that holds each result until the consumer takes it.
// ----------------------------------------------------------------------------
module lr_shift_reduce_parse_engine
   import lrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_state_index,
   input  logic [5:0] req_column_index,
   input  logic [1:0] req_action_code,
   input  logic [7:0] req_action_value,
   input  logic [7:0] req_goto_target,
   input  logic [7:0] req_rule_index,
   input  logic [4:0] req_rule_length,
   input  logic [5:0] req_rule_left,
   input  logic [5:0] req_token,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_result_kind,
   output logic [7:0] rsp_rule_number,
   output logic       rsp_last,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [6:0] csr_write_data
);

   item_type   in_item;
   item_type   head_item;
   logic       head_valid;
   logic       head_pop;
   result_type result;
   logic       out_ready;

   logic [6:0] tcount_ff, tcount_in;
   logic       conflict_ff, conflict_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_rule_ff, rsp_rule_in;
   logic       rsp_last_ff, rsp_last_in;

   assign in_item = '{kind: req_kind, state_index: req_state_index,
                      column_index: req_column_index, action_code: req_action_code,
                      action_value: req_action_value, goto_target: req_goto_target,
                      rule_index: req_rule_index, rule_length: req_rule_length,
                      rule_left: req_rule_left, token: req_token};

   lrp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_item    (in_item),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop)
   );

   lrp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .head_pop        (head_pop),
      .terminal_count  (tcount_ff),
      .tables_conflict (conflict_ff),
      .out_ready       (out_ready),
      .out_result      (result)
   );

   // The output register may be refilled in the cycle its result is taken.
   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      tcount_in   = tcount_ff;
      conflict_in = conflict_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TERMINAL_COUNT: tcount_in = csr_write_data;
            CSR_CONFLICT:       conflict_in = csr_write_data[0];
            default: ;
         endcase
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_rule_in  = rsp_rule_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_ready) begin
         rsp_valid_in = result.valid;
         if (result.valid) begin
            rsp_kind_in = result.kind;
            rsp_rule_in = (result.kind == RES_REDUCE) ? result.rule : 8'd0;
            rsp_last_in = result.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tcount_ff    <= MaxTerminals;
         conflict_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tcount_ff    <= tcount_in;
         conflict_ff  <= conflict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_rule_ff <= rsp_rule_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_rule_number = rsp_rule_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
